// ----- rtl/fsla_pkg.sv -----
// shared types, constants and helpers for the four-state logic alu
// no dependencies
`default_nettype none

package fsla_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned ShW   = $clog2(Width);

  typedef enum logic [4:0] {
    FN_AND    = 5'd0,
    FN_OR     = 5'd1,
    FN_XOR    = 5'd2,
    FN_NOT    = 5'd3,
    FN_EQ     = 5'd4,
    FN_NE     = 5'd5,
    FN_CASEEQ = 5'd6,
    FN_CASENE = 5'd7,
    FN_LAND   = 5'd8,
    FN_LOR    = 5'd9,
    FN_LNOT   = 5'd10,
    FN_LT     = 5'd11,
    FN_GT     = 5'd12,
    FN_LE     = 5'd13,
    FN_GE     = 5'd14,
    FN_SHL    = 5'd15,
    FN_SHR    = 5'd16,
    FN_ADD    = 5'd17,
    FN_SUB    = 5'd18,
    FN_MUL    = 5'd19,
    FN_DIV    = 5'd20,
    FN_MOD    = 5'd21,
    FN_NEG    = 5'd22
  } func_e;

  // three-valued truth: zero, one, unknown
  typedef enum logic [1:0] {
    TV_0 = 2'd0,
    TV_1 = 2'd1,
    TV_X = 2'd2
  } tri_e;

  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_DIV  = 2'd1,
    KIND_MOD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [4:0]       func;
    logic [Width-1:0] a_value;
    logic [Width-1:0] a_unknown;
    logic [Width-1:0] b_value;
    logic [Width-1:0] b_unknown;
  } req_t;

  typedef struct packed {
    logic [Width-1:0] r_value;
    logic [Width-1:0] r_unknown;
    logic             r_has_unknown;
  } rsp_t;

  // one pipeline slot: finished result or divider working set
  typedef struct packed {
    logic             vld;
    kind_e            kind;
    logic [Width-1:0] rv;
    logic [Width-1:0] ru;
    logic [Width-1:0] rem;
    logic [Width-1:0] quo;
    logic [Width-1:0] dvs;
  } stage_t;

  function automatic tri_e truth_of(logic [Width-1:0] v, logic [Width-1:0] u);
    tri_e t;
    if ((v & ~u) != '0) t = TV_1;
    else if (u != '0)   t = TV_X;
    else                t = TV_0;
    return t;
  endfunction

  function automatic tri_e invert3(tri_e t);
    tri_e r;
    unique case (t)
      TV_0:    r = TV_1;
      TV_1:    r = TV_0;
      default: r = TV_X;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fsla_decode.sv -----
// first stage: decodes the operation, evaluates all but divide and modulo
// depends on fsla_pkg
`default_nettype none

module fsla_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire fsla_pkg::req_t req_i,
  output fsla_pkg::stage_t    stage_o
);
  import fsla_pkg::*;

  logic [Width-1:0] av, au, bv, bu, a1, a0, b1, b0, prod;
  logic             anyu;
  tri_e             t, ta, tb;
  stage_t           stage_d, stage_q;
  logic             vld_q;

  assign av   = req_i.a_value;
  assign au   = req_i.a_unknown;
  assign bv   = req_i.b_value;
  assign bu   = req_i.b_unknown;
  assign a1   = av & ~au;
  assign a0   = ~av & ~au;
  assign b1   = bv & ~bu;
  assign b0   = ~bv & ~bu;
  assign anyu = (au | bu) != '0;
  assign prod = av * bv;
  assign ta   = truth_of(av, au);
  assign tb   = truth_of(bv, bu);

  always_comb begin
    stage_d      = '0;
    stage_d.vld  = valid_i;
    stage_d.kind = KIND_DONE;
    stage_d.rv   = '0;
    stage_d.ru   = '1;
    stage_d.quo  = av;
    stage_d.dvs  = bv;
    t            = TV_X;
    unique case (func_e'(req_i.func))
      FN_AND: begin
        stage_d.rv = a1 & b1;
        stage_d.ru = ~(a1 & b1 | a0 | b0);
      end
      FN_OR: begin
        stage_d.rv = a1 | b1;
        stage_d.ru = ~(a1 | b1 | (a0 & b0));
      end
      FN_XOR: begin
        stage_d.ru = au | bu;
        stage_d.rv = (av ^ bv) & ~(au | bu);
      end
      FN_NOT: begin
        stage_d.ru = au;
        stage_d.rv = a0;
      end
      FN_EQ, FN_NE: begin
        if (((av ^ bv) & ~au & ~bu) != '0) t = TV_0;
        else if (anyu)                      t = TV_X;
        else                                t = TV_1;
        if (func_e'(req_i.func) == FN_NE) t = invert3(t);
      end
      FN_CASEEQ: t = (av == bv && au == bu) ? TV_1 : TV_0;
      FN_CASENE: t = (av == bv && au == bu) ? TV_0 : TV_1;
      FN_LAND: begin
        if (ta == TV_0 || tb == TV_0)      t = TV_0;
        else if (ta == TV_1 && tb == TV_1) t = TV_1;
        else                               t = TV_X;
      end
      FN_LOR: begin
        if (ta == TV_1 || tb == TV_1)      t = TV_1;
        else if (ta == TV_0 && tb == TV_0) t = TV_0;
        else                               t = TV_X;
      end
      FN_LNOT: t = invert3(ta);
      FN_LT: t = anyu ? TV_X : ((av <  bv) ? TV_1 : TV_0);
      FN_GT: t = anyu ? TV_X : ((av >  bv) ? TV_1 : TV_0);
      FN_LE: t = anyu ? TV_X : ((av <= bv) ? TV_1 : TV_0);
      FN_GE: t = anyu ? TV_X : ((av >= bv) ? TV_1 : TV_0);
      FN_SHL, FN_SHR: begin
        if (bu != '0) begin
          stage_d.ru = '1;
        end else if (bv >= Width[Width-1:0]) begin
          stage_d.rv = '0;
          stage_d.ru = '0;
        end else if (func_e'(req_i.func) == FN_SHL) begin
          stage_d.rv = av << bv[ShW-1:0];
          stage_d.ru = au << bv[ShW-1:0];
        end else begin
          stage_d.rv = av >> bv[ShW-1:0];
          stage_d.ru = au >> bv[ShW-1:0];
        end
      end
      FN_ADD: if (!anyu) begin
        stage_d.rv = av + bv;
        stage_d.ru = '0;
      end
      FN_SUB: if (!anyu) begin
        stage_d.rv = av - bv;
        stage_d.ru = '0;
      end
      FN_MUL: if (!anyu) begin
        stage_d.rv = prod;
        stage_d.ru = '0;
      end
      FN_DIV: if (!anyu && bv != '0) stage_d.kind = KIND_DIV;
      FN_MOD: if (!anyu && bv != '0) stage_d.kind = KIND_MOD;
      FN_NEG: if (au == '0) begin
        stage_d.rv = '0 - av;
        stage_d.ru = '0;
      end
      default: ;
    endcase
    // single-bit operations land in bit 0
    unique case (func_e'(req_i.func))
      FN_EQ, FN_NE, FN_CASEEQ, FN_CASENE, FN_LAND, FN_LOR, FN_LNOT,
      FN_LT, FN_GT, FN_LE, FN_GE: begin
        stage_d.rv = {{(Width-1){1'b0}}, t == TV_1};
        stage_d.ru = {{(Width-1){1'b0}}, t == TV_X};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o     = stage_q;
    stage_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ----- rtl/fsla_div_stage.sv -----
// one restoring-division step with its pipeline register, one quotient bit
// depends on fsla_pkg
`default_nettype none

module fsla_div_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire fsla_pkg::stage_t stage_i,
  output fsla_pkg::stage_t      stage_o
);
  import fsla_pkg::*;

  logic [Width:0]   part, diff;
  logic             ge;
  stage_t           stage_d, stage_q;
  logic             vld_q;

  // shift the next dividend bit into the partial remainder
  assign part = {stage_i.rem, stage_i.quo[Width-1]};
  assign ge   = part >= {1'b0, stage_i.dvs};
  assign diff = part - {1'b0, stage_i.dvs};

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = ge ? diff[Width-1:0] : part[Width-1:0];
    stage_d.quo = {stage_i.quo[Width-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= stage_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  always_comb begin
    stage_o     = stage_q;
    stage_o.vld = vld_q;
  end

endmodule

`default_nettype wire

// ----- rtl/four_state_logic_alu_core.sv -----
// top level of the four-state logic alu: decode stage, divider chain, output register
// depends on fsla_pkg, fsla_decode, fsla_div_stage
`default_nettype none

// Evaluates one four-state operation per request on 32-bit operands held as value and
// unknown planes. A new request is taken every cycle unless the pipeline is frozen; each
// request passes through one decode stage, 32 divider stages at one quotient bit each and
// one output register; every operation rides through the bit-serial pipelined divider, so
// results leave in order. A stall on a valid output freezes the whole pipeline.
module four_state_logic_alu_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire fsla_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output fsla_pkg::rsp_t      out_data_o
);
  import fsla_pkg::*;

  logic   adv;
  stage_t pipe [0:Width];
  logic   out_valid_q;
  rsp_t   out_data_d, out_data_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  fsla_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .req_i   (in_data_i),
    .stage_o (pipe[0])
  );

  for (genvar i = 0; i < Width; i++) begin : g_div
    fsla_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .stage_i (pipe[i]),
      .stage_o (pipe[i+1])
    );
  end

  always_comb begin
    unique case (pipe[Width].kind)
      KIND_DIV: begin
        out_data_d.r_value   = pipe[Width].quo;
        out_data_d.r_unknown = '0;
      end
      KIND_MOD: begin
        out_data_d.r_value   = pipe[Width].rem;
        out_data_d.r_unknown = '0;
      end
      default: begin
        out_data_d.r_value   = pipe[Width].rv;
        out_data_d.r_unknown = pipe[Width].ru;
      end
    endcase
    out_data_d.r_has_unknown = |out_data_d.r_unknown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pipe[Width].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/fsla_checker.sv -----
// port-level checks for the four-state logic alu, bound to the top level
// depends on fsla_pkg and four_state_logic_alu_core
`default_nettype none

module fsla_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire fsla_pkg::req_t in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire fsla_pkg::rsp_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // summary flag agrees with the unknown plane
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.r_has_unknown == (out_data_o.r_unknown != '0))
    else $error("r_has_unknown mismatch");

  // a held result blocks new requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while pipeline frozen");

  // an open output lets requests in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without output stall");

  // a stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

endmodule

bind four_state_logic_alu_core fsla_checker u_fsla_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- tb/sv/four_state_logic_alu_core_tb.sv -----
// testbench for the four-state logic alu: random and directed requests, in-order result check
// depends on fsla_pkg and four_state_logic_alu_core
`default_nettype none

module four_state_logic_alu_core_tb;
  import fsla_pkg::*;

  localparam int unsigned NumRandom = 450;
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [Width-1:0] AllOnes = '1;

  // expected-result store with its own four-state predictor
  class alu_scoreboard;
    rsp_t pending_q[$];
    int unsigned mismatches;

    function tri_e truth3(logic [Width-1:0] v, logic [Width-1:0] u);
      tri_e t;
      if ((v & ~u) != '0) t = TV_1;
      else if (u != '0) t = TV_X;
      else t = TV_0;
      return t;
    endfunction

    function tri_e flip3(tri_e t);
      tri_e r;
      if (t == TV_X) r = TV_X;
      else if (t == TV_1) r = TV_0;
      else r = TV_1;
      return r;
    endfunction

    function rsp_t evaluate(req_t rq);
      rsp_t rs;
      logic [Width-1:0] av, au, bv, bu, a1, a0, b1, b0, rv, ru;
      logic any_unk;
      tri_e t, ta, tb;
      bit single;
      av = rq.a_value; au = rq.a_unknown; bv = rq.b_value; bu = rq.b_unknown;
      a1 = av & ~au; a0 = ~av & ~au; b1 = bv & ~bu; b0 = ~bv & ~bu;
      any_unk = (au | bu) != '0;
      rv = '0; ru = AllOnes; single = 0; t = TV_0;
      case (rq.func)
        FN_AND: begin rv = a1 & b1; ru = ~(rv | a0 | b0); end
        FN_OR: begin rv = a1 | b1; ru = ~(rv | (a0 & b0)); end
        FN_XOR: begin ru = au | bu; rv = (av ^ bv) & ~ru; end
        FN_NOT: begin ru = au; rv = ~av & ~au; end
        FN_EQ, FN_NE: begin
          single = 1;
          if (((av ^ bv) & ~au & ~bu) != '0) t = TV_0;
          else if (any_unk) t = TV_X;
          else t = TV_1;
          if (rq.func == FN_NE) t = flip3(t);
        end
        FN_CASEEQ, FN_CASENE: begin
          single = 1;
          t = (av == bv && au == bu) ? TV_1 : TV_0;
          if (rq.func == FN_CASENE) t = flip3(t);
        end
        FN_LAND, FN_LOR: begin
          single = 1;
          ta = truth3(av, au); tb = truth3(bv, bu);
          if (rq.func == FN_LAND)
            t = (ta == TV_0 || tb == TV_0) ? TV_0 :
                ((ta == TV_1 && tb == TV_1) ? TV_1 : TV_X);
          else
            t = (ta == TV_1 || tb == TV_1) ? TV_1 :
                ((ta == TV_0 && tb == TV_0) ? TV_0 : TV_X);
        end
        FN_LNOT: begin single = 1; t = flip3(truth3(av, au)); end
        FN_LT, FN_GT, FN_LE, FN_GE: begin
          single = 1;
          if (any_unk) t = TV_X;
          else begin
            case (rq.func)
              FN_LT: t = (av < bv) ? TV_1 : TV_0;
              FN_GT: t = (av > bv) ? TV_1 : TV_0;
              FN_LE: t = (av <= bv) ? TV_1 : TV_0;
              default: t = (av >= bv) ? TV_1 : TV_0;
            endcase
          end
        end
        FN_SHL, FN_SHR: begin
          if (bu == '0) begin
            if (bv >= Width) begin rv = '0; ru = '0; end
            else if (rq.func == FN_SHL) begin rv = av << bv; ru = au << bv; end
            else begin rv = av >> bv; ru = au >> bv; end
          end
        end
        FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_MOD: begin
          if (!any_unk && !((rq.func == FN_DIV || rq.func == FN_MOD) && bv == '0)) begin
            ru = '0;
            case (rq.func)
              FN_ADD: rv = av + bv;
              FN_SUB: rv = av - bv;
              FN_MUL: rv = av * bv;
              FN_DIV: rv = av / bv;
              default: rv = av % bv;
            endcase
          end
        end
        FN_NEG: if (au == '0) begin ru = '0; rv = '0 - av; end
        default: ;
      endcase
      if (single) begin
        rv = {{(Width-1){1'b0}}, t == TV_1};
        ru = {{(Width-1){1'b0}}, t == TV_X};
      end
      rs.r_value = rv;
      rs.r_unknown = ru;
      rs.r_has_unknown = (ru != '0);
      return rs;
    endfunction

    function void note_request(req_t rq);
      pending_q.push_back(evaluate(rq));
    endfunction

    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.r_value !== exp_r.r_value || got.r_unknown !== exp_r.r_unknown ||
          got.r_has_unknown !== exp_r.r_has_unknown) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp v=%h u=%h h=%b got v=%h u=%h h=%b",
                   exp_r.r_value, exp_r.r_unknown, exp_r.r_has_unknown,
                   got.r_value, got.r_unknown, got.r_has_unknown);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1;
  rsp_t out_data_o;

  alu_scoreboard sb = new();
  bit stim_done = 0;
  bit hold_off = 0;
  int unsigned idle_cycles = 0;
  req_t directed_q[$];

  four_state_logic_alu_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  function automatic logic [Width-1:0] rand_word();
    logic [Width-1:0] w;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = AllOnes;
      2: w = $urandom_range(0, 40);
      3: w = 32'h1 << $urandom_range(0, 31);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic req_t rand_request();
    req_t rq;
    rq.func = 5'(($urandom_range(0, 15) == 0) ? $urandom_range(23, 31)
                                              : $urandom_range(0, 22));
    rq.a_value = rand_word();
    rq.b_value = rand_word();
    // known operands most of the time so arithmetic gets exercised
    rq.a_unknown = ($urandom_range(0, 2) == 0) ? rand_word() : '0;
    rq.b_unknown = ($urandom_range(0, 2) == 0) ? rand_word() : '0;
    if (rq.func inside {FN_SHL, FN_SHR} && $urandom_range(0, 1)) rq.b_value = $urandom_range(0, 35);
    return rq;
  endfunction

  task automatic send_request(req_t rq);
    in_valid_i <= 1;
    in_data_i <= rq;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(rq);
  endtask

  task automatic sender_gap(int unsigned n);
    in_valid_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic build_directed();
    req_t rq;
    for (int f = 0; f <= 22; f++) begin
      rq.func = 5'(f);
      rq.a_value = (f % 2) ? AllOnes : 32'h8000_0005;
      rq.a_unknown = (f % 3 == 0) ? 32'h0000_0300 : '0;
      rq.b_value = (f >= FN_DIV && f <= FN_MOD && f == FN_DIV) ? '0 : 32'd3;
      rq.b_unknown = (f % 4 == 1) ? 32'h8000_0000 : '0;
      directed_q.push_back(rq);
    end
    rq = '{func: 5'd31, a_value: '0, a_unknown: '0, b_value: '0, b_unknown: '0};
    directed_q.push_back(rq);
    rq = '{func: FN_SHL, a_value: AllOnes, a_unknown: AllOnes, b_value: 32'd32, b_unknown: '0};
    directed_q.push_back(rq);
  endtask

  initial begin
    int unsigned gap;
    build_directed();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (directed_q[i]) send_request(directed_q[i]);
    for (int i = 0; i < NumRandom; i++) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
      if (i > 250 && i < 330) gap = 0;
      if (gap != 0) sender_gap(gap);
      send_request(rand_request());
    end
    in_valid_i <= 0;
    stim_done = 1;
  end

  // receiver: random stalls, plus one long hold-off that fills the pipeline
  initial begin
    int unsigned wait_n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (sb.pending_q.size() > 24 && !hold_off) begin
        hold_off = 1;
        out_stall_i <= 1;
        repeat (120) @(posedge clk_i);
        out_stall_i <= 0;
      end else if (out_valid_o && !out_stall_i) begin
        wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
        out_stall_i <= (wait_n != 0);
        repeat (wait_n) @(posedge clk_i);
        if (wait_n != 0) out_stall_i <= 0;
      end else begin
        out_stall_i <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // watchdog and end of run
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (stim_done && sb.pending_q.size() == 0) begin
        repeat (60) @(posedge clk_i);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
